// ===== hdl/adcsr_pkg.sv =====
package adcsr_pkg;

  localparam int READING_W = 24;
  localparam int FLOOR_W = 8;

  typedef enum logic [1:0] {
    ACT_BIT   = 2'd0,
    ACT_FLOOR = 2'd1,
    ACT_CAL   = 2'd2
  } action_t;

  typedef enum logic {
    REG_SKIP_UNSETTLED        = 1'b0,
    REG_CALIBRATE_EVERY_FRAME = 1'b1
  } reg_index_t;

  localparam logic [READING_W-1:0] FULL_SCALE_POS = 24'h7FFFFF;
  localparam logic [READING_W-1:0] FULL_SCALE_NEG = 24'h800000;

endpackage

// ===== hdl/adcsr_if.sv =====
interface adcsr_sample_if
  import adcsr_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic               data_bit;
  logic [FLOOR_W-1:0] discard_floor;

  modport source (output valid, action, data_bit, discard_floor, input ready);
  modport sink (input valid, action, data_bit, discard_floor, output ready);
endinterface

interface adcsr_result_if
  import adcsr_pkg::*;
  ;
  logic                        valid;
  logic                        ready;
  logic signed [READING_W-1:0] reading;
  logic                        reading_updated;
  logic                        overrange;
  logic                        calibration_pulse;
  logic [FLOOR_W-1:0]          discards_left;

  modport source (output valid, reading, reading_updated, overrange, calibration_pulse,
                  discards_left, input ready);
  modport sink (input valid, reading, reading_updated, overrange, calibration_pulse,
                discards_left, output ready);
endinterface

// ===== hdl/adc_serial_readout_settling.sv =====
// Serial readout of a delta-sigma converter with settling skip and calibration request.
// sample channel: one beat per event: a sampled data-out bit (MSB first), a settling
//   floor raise, or a one-shot calibration request.
// result channel: one beat per completed frame of DATA_BITS data bits, carrying the
//   stored reading, whether it was replaced, the overrange flag, whether the trailing
//   calibration pulse follows, and the settling readings still to come.
// cfg port: cfg_we/cfg_index/cfg_data write skip_unsettled (0) and
//   calibrate_every_frame (1); write only while no beat is in flight.
// Output: registered result beat, valid in the cycle after the frame's last sample beat.
// Throughput: one sample beat per cycle while sample.ready is high; the shift, counter
//   and settle update is combinational logic feeding the output register.
// Stall: sample.ready stays high while the output register is empty or being taken
//   in the same cycle; while a result beat waits, sample beats are held off.
// Reset: clears the shift word, bit counter, settle count, held reading, overrange and
//   pending calibration, sets skip_unsettled and clears calibrate_every_frame.
module adc_serial_readout_settling
  import adcsr_pkg::*;
#(
  parameter int DATA_BITS = 24
) (
  input  logic           clk,
  input  logic           rst,
  adcsr_sample_if.sink   sample,
  adcsr_result_if.source result,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic           cfg_data
);

  localparam int CNT_W = $clog2(DATA_BITS);

  logic [DATA_BITS-1:0] shift_word;
  logic [CNT_W-1:0]     bit_count;
  logic [FLOOR_W-1:0]   settle_count;
  logic [READING_W-1:0] held_reading;
  logic                 held_overrange;
  logic                 calibration_pending;
  logic                 skip_unsettled;
  logic                 calibrate_every_frame;

  logic                           accept;
  logic                           frame_done;
  logic [DATA_BITS-1:0]           shift_next;
  logic [DATA_BITS+READING_W-1:0] aligned;
  logic [READING_W-1:0]           frame_reading;
  logic                           hold;
  logic                           cal;
  logic [FLOOR_W-1:0]             settle_dec;

  assign sample.ready = !result.valid || result.ready;
  assign accept = sample.valid && sample.ready;

  assign shift_next = {shift_word[DATA_BITS-2:0], sample.data_bit};
  assign aligned = {shift_next, {READING_W{1'b0}}};
  assign frame_reading = aligned[DATA_BITS+READING_W-1 -: READING_W];

  assign frame_done = accept && (action_t'(sample.action) == ACT_BIT)
                      && (bit_count == CNT_W'(DATA_BITS - 1));
  assign hold = skip_unsettled && (settle_count != '0);
  assign cal = calibration_pending || calibrate_every_frame;
  assign settle_dec = (settle_count != '0) ? settle_count - 1'b1 : settle_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_unsettled <= 1'b1;
      calibrate_every_frame <= 1'b0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_SKIP_UNSETTLED:        skip_unsettled <= cfg_data;
        REG_CALIBRATE_EVERY_FRAME: calibrate_every_frame <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_word <= '0;
      bit_count <= '0;
      settle_count <= '0;
      held_reading <= '0;
      held_overrange <= 1'b0;
      calibration_pending <= 1'b0;
    end else if (accept) begin
      case (action_t'(sample.action))
        ACT_BIT: begin
          if (frame_done) begin
            shift_word <= '0;
            bit_count <= '0;
            settle_count <= settle_dec;
            if (cal) calibration_pending <= 1'b0;
            if (!hold) begin
              held_reading <= frame_reading;
              held_overrange <= (frame_reading == FULL_SCALE_POS)
                                || (frame_reading == FULL_SCALE_NEG);
            end
          end else begin
            shift_word <= shift_next;
            bit_count <= bit_count + 1'b1;
          end
        end
        ACT_FLOOR: begin
          if (sample.discard_floor > settle_count) settle_count <= sample.discard_floor;
        end
        ACT_CAL: calibration_pending <= 1'b1;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (frame_done) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      result.reading <= hold ? held_reading : frame_reading;
      result.reading_updated <= !hold;
      result.overrange <= hold ? held_overrange
                               : ((frame_reading == FULL_SCALE_POS)
                                  || (frame_reading == FULL_SCALE_NEG));
      result.calibration_pulse <= cal;
      result.discards_left <= settle_dec;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= CNT_W'(DATA_BITS - 1))
    else $error("bit counter past frame end");

  a_rise_from_frame: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(accept))
    else $error("result beat without a sample beat");

  a_overrange_match: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.reading_updated |->
      result.overrange == ((result.reading == FULL_SCALE_POS)
                           || (result.reading == FULL_SCALE_NEG)))
    else $error("overrange flag does not match reading");

  a_cal_clears: assert property (@(posedge clk) disable iff (rst)
    frame_done && !calibrate_every_frame && calibration_pending
    && !(cfg_we && cfg_index) |=> !calibration_pending || $past(!frame_done))
    else $error("pending calibration not cleared");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb
  import adcsr_pkg::*;
  ;

  localparam int FRAME_BITS = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int FRAMES_PER_PHASE = 6;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic               data_bit;
    logic [FLOOR_W-1:0] discard_floor;
  } sample_item_t;

  typedef struct packed {
    logic [READING_W-1:0] reading;
    logic                 reading_updated;
    logic                 overrange;
    logic                 calibration_pulse;
    logic [FLOOR_W-1:0]   discards_left;
  } frame_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic cfg_data;

  adcsr_sample_if smp ();
  adcsr_result_if res ();

  adc_serial_readout_settling uut (
    .clk      (clk),
    .rst      (rst),
    .sample   (smp),
    .result   (res),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  sample_item_t  pending_q[$];
  frame_result_t frame_results_q[$];

  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;
  bit pressure_go;
  bit hold_used;
  int hold_left;

  // predicted readout state
  logic [FRAME_BITS-1:0] pr_shift;
  int unsigned           pr_bits;
  logic [FLOOR_W-1:0]    pr_settle;
  logic [READING_W-1:0]  pr_reading;
  logic                  pr_over;
  logic                  pr_cal_pending;
  logic                  pr_skip;
  logic                  pr_cal_every;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic step_readout(input sample_item_t it);
    frame_result_t r;
    logic cal;
    case (it.action)
      ACT_FLOOR: begin
        if (it.discard_floor > pr_settle) pr_settle = it.discard_floor;
      end
      ACT_CAL: begin
        pr_cal_pending = 1'b1;
      end
      ACT_BIT: begin
        pr_shift = {pr_shift[FRAME_BITS-2:0], it.data_bit};
        pr_bits++;
        if (pr_bits == FRAME_BITS) begin
          pr_bits = 0;
          cal = pr_cal_pending | pr_cal_every;
          if (cal) pr_cal_pending = 1'b0;
          if (pr_skip && pr_settle != 0) begin
            r.reading_updated = 1'b0;
          end else begin
            pr_reading = pr_shift[FRAME_BITS-1 -: READING_W];
            pr_over = (pr_reading == FULL_SCALE_POS) || (pr_reading == FULL_SCALE_NEG);
            r.reading_updated = 1'b1;
          end
          if (pr_settle != 0) pr_settle--;
          pr_shift = '0;
          r.reading = pr_reading;
          r.overrange = pr_over;
          r.calibration_pulse = cal;
          r.discards_left = pr_settle;
          frame_results_q.push_back(r);
        end
      end
      default: begin
      end
    endcase
  endtask

  // driver: one beat per accepted sample
  always @(posedge clk) begin
    sample_item_t took;
    sample_item_t nxt;
    if (rst) begin
      smp.valid <= 1'b0;
    end else begin
      if (smp.valid && smp.ready) begin
        took.action = smp.action;
        took.data_bit = smp.data_bit;
        took.discard_floor = smp.discard_floor;
        step_readout(took);
      end
      if (!smp.valid || smp.ready) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_q.pop_front();
          smp.valid <= 1'b1;
          smp.action <= nxt.action;
          smp.data_bit <= nxt.data_bit;
          smp.discard_floor <= nxt.discard_floor;
        end else begin
          smp.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result beat against the oldest prediction
  always @(posedge clk) begin
    frame_result_t exp_r;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (frame_results_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          exp_r = frame_results_q.pop_front();
          if (res.reading !== exp_r.reading) begin
            $error("reading: expected %h, got %h", exp_r.reading, res.reading);
            errors++;
          end
          if (res.reading_updated !== exp_r.reading_updated) begin
            $error("reading_updated: expected %b, got %b", exp_r.reading_updated,
                   res.reading_updated);
            errors++;
          end
          if (res.overrange !== exp_r.overrange) begin
            $error("overrange: expected %b, got %b", exp_r.overrange, res.overrange);
            errors++;
          end
          if (res.calibration_pulse !== exp_r.calibration_pulse) begin
            $error("calibration_pulse: expected %b, got %b", exp_r.calibration_pulse,
                   res.calibration_pulse);
            errors++;
          end
          if (res.discards_left !== exp_r.discards_left) begin
            $error("discards_left: expected %0d, got %0d", exp_r.discards_left,
                   res.discards_left);
            errors++;
          end
        end
      end
      if (pressure_go && !hold_used) begin
        hold_used <= 1'b1;
        hold_left <= HOLD_CYCLES;
        res.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (res.valid && res.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic write_reg(input reg_index_t idx, input logic val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SKIP_UNSETTLED) pr_skip = val;
    else pr_cal_every = val;
  endtask

  task automatic push_item(input logic [1:0] act, input logic b, input logic [7:0] fl);
    sample_item_t it;
    it.action = act;
    it.data_bit = b;
    it.discard_floor = fl;
    pending_q.push_back(it);
  endtask

  task automatic queue_control(input bit wide_floors);
    int pick;
    logic [7:0] fl;
    pick = $urandom_range(0, 9);
    fl = wide_floors ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
    if (pick < 4) push_item(ACT_FLOOR, 1'($urandom), fl);
    else if (pick < 8) push_item(ACT_CAL, 1'($urandom), 8'($urandom));
    else push_item(ACT_UNUSED, 1'($urandom), 8'($urandom));
  endtask

  task automatic queue_frame(input bit wide_floors);
    int pick;
    logic [FRAME_BITS-1:0] word;
    pick = $urandom_range(0, 7);
    case (pick)
      0: word = '0;
      1: word = '1;
      2: word = FULL_SCALE_POS;
      3: word = FULL_SCALE_NEG;
      default: word = FRAME_BITS'($urandom);
    endcase
    for (int i = FRAME_BITS - 1; i >= 0; i--) begin
      if ($urandom_range(0, 15) == 0) queue_control(wide_floors);
      push_item(ACT_BIT, word[i], 8'($urandom));
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_q.size() != 0 || smp.valid) @(negedge clk);
    while (frame_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic skip, input logic cal_every, input int s_idle,
                           input int r_idle, input bit wide_floors);
    wait_idle();
    write_reg(REG_SKIP_UNSETTLED, skip);
    write_reg(REG_CALIBRATE_EVERY_FRAME, cal_every);
    @(negedge clk);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int f = 0; f < FRAMES_PER_PHASE; f++) queue_frame(wide_floors);
  endtask

  initial begin
    logic [FRAME_BITS-1:0] word;
    errors = 0;
    stall_cycles = 0;
    pressure_go = 1'b0;
    hold_used = 1'b0;
    hold_left = 0;
    send_idle_pct = 30;
    recv_idle_pct = 49;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = 1'b0;
    smp.valid = 1'b0;
    smp.action = ACT_BIT;
    smp.data_bit = 1'b0;
    smp.discard_floor = '0;
    res.ready = 1'b0;
    pr_shift = '0;
    pr_bits = 0;
    pr_settle = '0;
    pr_reading = '0;
    pr_over = 1'b0;
    pr_cal_pending = 1'b0;
    pr_skip = 1'b1;
    pr_cal_every = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_SKIP_UNSETTLED, 1'b1);
    write_reg(REG_CALIBRATE_EVERY_FRAME, 1'b0);

    // full-scale frame with floor, calibration and unused beats mid-frame
    word = FULL_SCALE_POS;
    for (int i = FRAME_BITS - 1; i >= 0; i--) begin
      if (i == 15) begin
        push_item(ACT_FLOOR, 1'b1, 8'd0);
        push_item(ACT_UNUSED, 1'b0, 8'hFF);
        push_item(ACT_CAL, 1'b1, 8'hAA);
      end
      push_item(ACT_BIT, word[i], 8'h55);
    end
    for (int f = 0; f < FRAMES_PER_PHASE; f++) queue_frame(1'b0);

    run_phase(1'b1, 1'b1, 49, 30, 1'b0);
    run_phase(1'b0, 1'b0, 0, 0, 1'b1);
    pressure_go = 1'b1;
    run_phase(1'b1, 1'b1, 0, 0, 1'b0);
    run_phase(1'b0, 1'b1, 0, 0, 1'b0);

    wait_idle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== adc_serial_readout_settling.f =====
hdl/adcsr_pkg.sv
hdl/adcsr_if.sv
hdl/adc_serial_readout_settling.sv
tb/sv/tb.sv
